/* sv/rca_pkg.sv */
// Shared types, constants and helper functions for the RGB555 colour adjust block.
`timescale 1ns / 1ps
`default_nettype none

package rca_pkg;

  localparam int NUM_CH      = 3;
  localparam int CH_W        = 8;
  localparam int FIVE_W      = 5;
  localparam int PIXEL_W     = 15;
  localparam int CURVE_DEPTH = 256;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 24;
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = 1;
  localparam int FIFO_CNT_W  = 2;
  localparam int CFG_IDX_W   = 2;

  // Field placement on the input tdata
  localparam int PIX_LO  = 0;
  localparam int CIDX_LO = 15;
  localparam int CVAL_LO = 23;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_EN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONTRAST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_EN  = 2'd3;

  localparam logic [CH_W-1:0] LEVEL_RESET   = 8'd100;
  localparam logic signed [8:0] LEVEL_MID   = 9'sd100;
  localparam logic signed [18:0] ROUND_BIAS = 19'sd127;
  localparam logic [16:0] DIVISOR           = 17'd255;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_CURVE = 1'b1
  } kind_t;

  typedef struct packed {
    logic            ramp_en;
    logic [CH_W-1:0] contrast;
    logic [CH_W-1:0] bright;
    logic            curve_en;
  } cfg_t;

  typedef struct packed {
    kind_t                       kind;
    logic [NUM_CH-1:0][CH_W-1:0] chan;
    logic [CH_W-1:0]             cidx;
    logic [CH_W-1:0]             cval;
  } item_t;

  typedef struct packed {
    logic [FIFO_CNT_W-1:0] count;
    logic                  full;
    logic                  empty;
  } fifo_stat_t;

  // Fixed 32-step gamma ramp
  function automatic logic [CH_W-1:0] ramp_lut(input logic [FIVE_W-1:0] v);
    logic [CH_W-1:0] r;
    case (v)
      5'd0:  r = 8'h00;  5'd1:  r = 8'h01;  5'd2:  r = 8'h03;  5'd3:  r = 8'h06;
      5'd4:  r = 8'h0a;  5'd5:  r = 8'h0f;  5'd6:  r = 8'h15;  5'd7:  r = 8'h1c;
      5'd8:  r = 8'h24;  5'd9:  r = 8'h2d;  5'd10: r = 8'h37;  5'd11: r = 8'h42;
      5'd12: r = 8'h4e;  5'd13: r = 8'h5b;  5'd14: r = 8'h69;  5'd15: r = 8'h78;
      5'd16: r = 8'h88;  5'd17: r = 8'h90;  5'd18: r = 8'h98;  5'd19: r = 8'ha0;
      5'd20: r = 8'ha8;  5'd21: r = 8'hb0;  5'd22: r = 8'hb8;  5'd23: r = 8'hc0;
      5'd24: r = 8'hc8;  5'd25: r = 8'hd0;  5'd26: r = 8'hd8;  5'd27: r = 8'he0;
      5'd28: r = 8'he8;  5'd29: r = 8'hf0;  5'd30: r = 8'hf8;  5'd31: r = 8'hff;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Level to signed offset around neutral
  function automatic logic signed [8:0] level_offset(input logic [CH_W-1:0] lvl);
    return $signed({1'b0, lvl}) - LEVEL_MID;
  endfunction

  function automatic logic [CH_W-1:0] clamp_byte(input logic signed [10:0] v);
    logic [CH_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > 11'sd255) begin
      r = 8'hff;
    end else begin
      r = v[CH_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/rca_front.sv */
// Front end: accept beats, classify them and widen or ramp-map each channel.
`timescale 1ns / 1ps
`default_nettype none

module rca_front (
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [rca_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                           in_tuser,
  input  wire rca_pkg::cfg_t                  cfg,
  input  wire logic                           q_full,
  output logic                                q_push,
  output rca_pkg::item_t                      q_item
);
  import rca_pkg::*;

  logic [PIXEL_W-1:0] pixel;

  assign pixel     = in_tdata[PIX_LO +: PIXEL_W];
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_item.kind = kind_t'(in_tuser);
    q_item.cidx = in_tdata[CIDX_LO +: CH_W];
    q_item.cval = in_tdata[CVAL_LO +: CH_W];
    for (int i = 0; i < NUM_CH; i++) begin
      // lane i takes pixel bits i*5 up, so the top lane lands in the top result byte
      if (cfg.ramp_en) begin
        q_item.chan[i] = ramp_lut(pixel[i*FIVE_W +: FIVE_W]);
      end else begin
        q_item.chan[i] = {pixel[i*FIVE_W +: FIVE_W],
                          pixel[i*FIVE_W + 2 +: 3]};
      end
    end
  end

endmodule

`default_nettype wire

/* sv/rca_fifo.sv */
// Two-entry queue between the front end and the adjust pipeline.
`timescale 1ns / 1ps
`default_nettype none

module rca_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire rca_pkg::item_t   push_item,
  input  wire logic             pop,
  output rca_pkg::item_t        head,
  output rca_pkg::fifo_stat_t   stat
);
  import rca_pkg::*;

  item_t                 slot_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;

  assign head       = slot_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.full  = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* sv/rca_back.sv */
// Back end: contrast, brightness and loadable gamma curve, four stages per channel.
`timescale 1ns / 1ps
`default_nettype none

module rca_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire rca_pkg::cfg_t                   cfg,
  input  wire logic                            head_valid,
  input  wire rca_pkg::item_t                  head,
  output logic                                 pop,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [rca_pkg::OUT_DATA_W-1:0]       out_tdata
);
  import rca_pkg::*;

  logic adv;
  logic signed [8:0] c_off, b_off;

  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  kind_t s1_kind_r, s2_kind_r, s3_kind_r, s4_kind_r;
  logic [CH_W-1:0] s1_cidx_r, s2_cidx_r, s3_cidx_r;
  logic [CH_W-1:0] s1_cval_r, s2_cval_r, s3_cval_r;

  logic [NUM_CH-1:0][CH_W-1:0] s1_x_r, s2_x_r;
  logic [NUM_CH-1:0][18:0]     s1_p_r, p_nxt;
  logic [NUM_CH-1:0][16:0]     s2_m_r, m_nxt;
  logic [NUM_CH-1:0][8:0]      s2_q0_r, q0_nxt;
  logic [NUM_CH-1:0]           s2_neg_r;
  logic [NUM_CH-1:0][CH_W-1:0] s3_y_r, y_nxt;
  logic [NUM_CH-1:0][CH_W-1:0] s4_z_r, z_nxt;
  logic [NUM_CH-1:0][CH_W-1:0] rd_all;

  logic signed [17:0]     prod   [NUM_CH];
  logic [18:0]            mag    [NUM_CH];
  logic [24:0]            m257   [NUM_CH];
  logic [16:0]            q0x255 [NUM_CH];
  logic [16:0]            rem    [NUM_CH];
  logic [8:0]             quo    [NUM_CH];
  logic signed [10:0]     qs     [NUM_CH];
  logic signed [10:0]     con    [NUM_CH];
  logic signed [10:0]     bri    [NUM_CH];

  assign c_off = level_offset(cfg.contrast);
  assign b_off = level_offset(cfg.bright);

  // Hold the whole pipeline while a result waits at the output
  assign adv        = !out_tvalid || out_tready;
  assign pop        = adv && head_valid;
  assign out_tvalid = s4_vld_r && (s4_kind_r == KIND_PIXEL);
  assign out_tdata  = cfg.curve_en ? rd_all : s4_z_r;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      // stage 1: 2*c*x + 127
      prod[i]  = $signed({1'b0, head.chan[i]}) * c_off;
      p_nxt[i] = $signed({prod[i], 1'b0}) + ROUND_BIAS;
      // stage 2: magnitude and first quotient guess, x*257/65536 never overshoots
      mag[i]    = s1_p_r[i][18] ? (19'd0 - s1_p_r[i]) : s1_p_r[i];
      m_nxt[i]  = mag[i][16:0];
      m257[i]   = {m_nxt[i], 8'd0} + {8'd0, m_nxt[i]};
      q0_nxt[i] = m257[i][24:16];
      // stage 3: correct the guess by one, apply sign, then contrast
      q0x255[i] = {s2_q0_r[i], 8'd0} - {8'd0, s2_q0_r[i]};
      rem[i]    = s2_m_r[i] - q0x255[i];
      quo[i]    = s2_q0_r[i] + 9'(rem[i] >= DIVISOR);
      qs[i]     = s2_neg_r[i] ? (11'sd0 - $signed({2'b0, quo[i]}))
                              : $signed({2'b0, quo[i]});
      con[i]    = $signed({3'b0, s2_x_r[i]}) - $signed({{2{c_off[8]}}, c_off}) + qs[i];
      y_nxt[i]  = clamp_byte(con[i]);
      // stage 4: brightness
      bri[i]    = $signed({3'b0, s3_y_r[i]}) + $signed({{2{b_off[8]}}, b_off});
      z_nxt[i]  = clamp_byte(bri[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= head_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind_r <= head.kind;
      s1_cidx_r <= head.cidx;
      s1_cval_r <= head.cval;
      s1_x_r    <= head.chan;
      s1_p_r    <= p_nxt;
      s2_kind_r <= s1_kind_r;
      s2_cidx_r <= s1_cidx_r;
      s2_cval_r <= s1_cval_r;
      s2_x_r    <= s1_x_r;
      s2_m_r    <= m_nxt;
      s2_q0_r   <= q0_nxt;
      for (int i = 0; i < NUM_CH; i++) begin
        s2_neg_r[i] <= s1_p_r[i][18];
      end
      s3_kind_r <= s2_kind_r;
      s3_cidx_r <= s2_cidx_r;
      s3_cval_r <= s2_cval_r;
      s3_y_r    <= y_nxt;
      s4_kind_r <= s3_kind_r;
      s4_z_r    <= z_nxt;
    end
  end

  // One curve copy per channel; writes land at the same stage that issues reads,
  // so a pixel always sees every curve write that came before it.
  for (genvar i = 0; i < NUM_CH; i++) begin : g_curve
    logic [CH_W-1:0] mem [CURVE_DEPTH];
    logic [CH_W-1:0] rd_r;

    always_ff @(posedge clk) begin
      if (adv && s3_vld_r && (s3_kind_r == KIND_CURVE)) begin
        mem[s3_cidx_r] <= s3_cval_r;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rd_r <= mem[z_nxt[i]];
      end
    end

    assign rd_all[i] = rd_r;
  end

endmodule

`default_nettype wire

/* sv/rgb555_color_adjust.sv */
// Top level: RGB555 to RGB888 conversion with ramp, contrast, brightness and gamma curve.
//
//  Channel  Dir  Payload                                              Handshake
//  in_      in   tuser: mode; tdata: pixel, curve_index, curve_value  tvalid/tready
//  out_     out  tdata: color                                         tvalid/tready
//  cfg_     in   index 0..3, data 8 bits                               valid/ready
//
//  One beat per clock in and out when nothing stalls; a pixel result passes the
//  queue, then the four stages of the adjust pipeline, before it leaves.
//  The whole pipeline holds while a result waits; the two-entry queue absorbs the
//  input side. Reset restores the register defaults and empties queue and pipeline;
//  the gamma curve store is not cleared and holds nothing defined until written.
//  Configuration writes are taken every cycle.
`timescale 1ns / 1ps
`default_nettype none

module rgb555_color_adjust (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [rca_pkg::IN_DATA_W-1:0]     in_tdata,   // pixel, curve_index, curve_value, 0
  input  wire logic                              in_tuser,   // mode
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [rca_pkg::OUT_DATA_W-1:0]         out_tdata,  // color
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rca_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rca_pkg::CH_W-1:0]          cfg_data
);
  import rca_pkg::*;

  cfg_t       cfg_r;
  logic       push, pop;
  item_t      push_item, head;
  fifo_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ramp_en  <= 1'b1;
      cfg_r.contrast <= LEVEL_RESET;
      cfg_r.bright   <= LEVEL_RESET;
      cfg_r.curve_en <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RAMP_EN:  cfg_r.ramp_en  <= cfg_data[0];
        REG_CONTRAST: cfg_r.contrast <= cfg_data;
        REG_BRIGHT:   cfg_r.bright   <= cfg_data;
        REG_CURVE_EN: cfg_r.curve_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rca_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg_r),
    .q_full    (stat.full),
    .q_push    (push),
    .q_item    (push_item)
  );

  rca_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  rca_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (!stat.empty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !in_tready)
    else $error("input accepted while queue full");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push || pop) |=>
      stat.count == $past(stat.count) + FIFO_CNT_W'($past(push)) - FIFO_CNT_W'($past(pop)))
    else $error("queue count out of step with push and pop");

  a_quiet_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result offered straight after reset");

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the RGB555 to RGB888 colour adjust block.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import rca_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_AT      = 60;
  localparam int HOLD_CYCLES  = 90;

  localparam logic [7:0] RAMP_STEPS [0:31] = '{
    8'h00, 8'h01, 8'h03, 8'h06, 8'h0a, 8'h0f, 8'h15, 8'h1c,
    8'h24, 8'h2d, 8'h37, 8'h42, 8'h4e, 8'h5b, 8'h69, 8'h78,
    8'h88, 8'h90, 8'h98, 8'ha0, 8'ha8, 8'hb0, 8'hb8, 8'hc0,
    8'hc8, 8'hd0, 8'hd8, 8'he0, 8'he8, 8'hf0, 8'hf8, 8'hff
  };

  typedef struct {
    kind_t       kind;
    logic [14:0] pixel;
    logic [7:0]  cidx;
    logic [7:0]  cval;
  } beat_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  wire                  in_tready;
  logic [IN_DATA_W-1:0] in_tdata   = '0;   // pixel, curve_index, curve_value, 0
  logic                 in_tuser   = 1'b0; // mode
  wire                  out_tvalid;
  logic                 out_tready = 1'b0;
  wire [OUT_DATA_W-1:0] out_tdata;         // color
  logic                 cfg_valid  = 1'b0;
  wire                  cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [7:0]           cfg_data   = '0;

  // Shadow of the block's registers and curve store
  logic       ramp_on      = 1'b1;
  logic [7:0] contrast_lvl = 8'd100;
  logic [7:0] bright_lvl   = 8'd100;
  logic       curve_on     = 1'b0;
  logic [7:0] curve_mem [256];

  beat_t       beat_q [$];
  beat_t       cur_beat;
  logic [23:0] color_q [$];

  int   pushed_total   = 0;
  int   accepted_total = 0;
  int   pixels_checked = 0;
  int   curve_writes   = 0;
  int   error_count    = 0;
  int   settings_run   = 0;
  int   cycle_count    = 0;
  int   src_gap        = 0;
  int   sink_gap       = 0;
  int   hold_left      = 0;
  logic hold_done      = 1'b0;
  logic calm_tail      = 1'b0;

  rgb555_color_adjust dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int limit_byte(input int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  function automatic logic [7:0] adjust_chan(input logic [4:0] five);
    int x;
    int c;
    int b;
    c = int'(contrast_lvl) - 100;
    b = int'(bright_lvl) - 100;
    x = ramp_on ? int'(RAMP_STEPS[five]) : int'({five, five[4:2]});
    // signed division truncates toward zero
    x = limit_byte(x - c + (2 * c * x + 127) / 255);
    x = limit_byte(x + b);
    if (curve_on) x = int'(curve_mem[x[7:0]]);
    return x[7:0];
  endfunction

  function automatic logic [23:0] convert_pixel(input logic [14:0] p);
    return {adjust_chan(p[14:10]), adjust_chan(p[9:5]), adjust_chan(p[4:0])};
  endfunction

  function automatic logic [14:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return 15'h0000;
      1: return 15'h7fff;
      default: return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic logic [7:0] rand_level();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd100;
      2: return 8'd200;
      3: return 8'd255;
      default: return 8'($urandom_range(0, 200));
    endcase
  endfunction

  task automatic push_beat(input kind_t k, input logic [14:0] p,
                           input logic [7:0] idx, input logic [7:0] val);
    beat_t bt;
    bt.kind  = k;
    bt.pixel = p;
    bt.cidx  = idx;
    bt.cval  = val;
    beat_q.push_back(bt);
    pushed_total++;
  endtask

  task automatic push_pixel(input logic [14:0] p);
    push_beat(KIND_PIXEL, p, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic push_curve(input logic [7:0] idx, input logic [7:0] val);
    push_beat(KIND_CURVE, 15'($urandom_range(0, 32767)), idx, val);
  endtask

  // Call right after a rising edge; returns right after one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_RAMP_EN:  ramp_on      = val[0];
      REG_CONTRAST: contrast_lvl = val;
      REG_BRIGHT:   bright_lvl   = val;
      REG_CURVE_EN: curve_on     = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic ramp, input logic [7:0] con, input logic [7:0] bri,
                          input logic cur);
    write_reg(REG_RAMP_EN, {7'd0, ramp});
    write_reg(REG_CONTRAST, con);
    write_reg(REG_BRIGHT, bri);
    write_reg(REG_CURVE_EN, {7'd0, cur});
    settings_run++;
  endtask

  // Hold until every beat is taken and every colour has come back, then let the
  // pipeline run dry since curve writes leave nothing to wait for.
  task automatic wait_idle();
    while (accepted_total != pushed_total || color_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic sweep_step(input logic ramp, input logic [7:0] con, input logic [7:0] bri);
    set_regs(ramp, con, bri, 1'b0);
    push_pixel(15'h7fff);
    push_pixel(15'h4631);
    wait_idle();
  endtask

  task automatic run_random(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 6) == 0)
        push_curve(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      else
        push_pixel(rand_pixel());
    end
    wait_idle();
  endtask

  // Source side: predict on each accepted beat, then offer the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (cur_beat.kind == KIND_CURVE) begin
          curve_mem[cur_beat.cidx] = cur_beat.cval;
          curve_writes++;
        end else begin
          color_q.push_back(convert_pixel(cur_beat.pixel));
        end
        accepted_total++;
      end
      if (!in_tvalid || in_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_tvalid <= 1'b0;
        end else if (beat_q.size() > 0) begin
          cur_beat = beat_q.pop_front();
          in_tdata  <= {1'b0, cur_beat.cval, cur_beat.cidx, cur_beat.pixel};
          in_tuser  <= cur_beat.kind;
          in_tvalid <= 1'b1;
          if (!calm_tail && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 5);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink side: check each colour beat against the oldest prediction.
  always @(posedge clk) begin
    logic [23:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (color_q.size() == 0) begin
          error_count++;
          $display("%0t ns: colour beat %06h with nothing expected", $time, out_tdata);
        end else begin
          want = color_q.pop_front();
          pixels_checked++;
          if (out_tdata !== want) begin
            error_count++;
            $display("%0t ns: colour expected %06h, got %06h", $time, want, out_tdata);
          end
        end
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_tready <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 6) == 0) begin
        sink_gap = $urandom_range(0, 4);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Long back-pressure stretch once the stream is under way
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_total >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d colours still awaited", cycle_count,
               color_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int i;
    int p;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // Reset defaults: field extremes, single channels, alternating bits, two curve writes
    push_pixel(15'h0000);
    push_pixel(15'h7fff);
    push_pixel(15'h7c00);
    push_pixel(15'h03e0);
    push_pixel(15'h001f);
    push_pixel(15'h5555);
    push_pixel(15'h2aaa);
    push_beat(KIND_CURVE, 15'h7fff, 8'd0, 8'haa);
    push_beat(KIND_CURVE, 15'h0000, 8'd255, 8'h55);
    push_beat(KIND_PIXEL, 15'h1234, 8'hff, 8'hff);
    wait_idle();

    // Curve on with only the end entries loaded: read nothing else
    set_regs(1'b1, 8'd100, 8'd100, 1'b1);
    push_pixel(15'h0000);
    push_pixel(15'h7fff);
    push_pixel(15'h7c1f);
    wait_idle();

    // Level extremes, including levels beyond the nominal range
    sweep_step(1'b0, 8'd100, 8'd100);
    sweep_step(1'b1, 8'd0, 8'd100);
    sweep_step(1'b1, 8'd255, 8'd0);
    sweep_step(1'b0, 8'd200, 8'd255);
    sweep_step(1'b0, 8'd0, 8'd200);

    // Curve still partly unwritten: keep it off here
    set_regs(1'($urandom_range(0, 1)), rand_level(), rand_level(), 1'b0);
    run_random(60);

    // Load the whole curve so any channel may read it from now on
    for (i = 0; i < 256; i++) push_curve(8'(i), 8'($urandom_range(0, 255)));
    wait_idle();

    for (p = 0; p < 7; p++) begin
      if (p == 6) calm_tail <= 1'b1;
      set_regs(1'($urandom_range(0, 1)), rand_level(), rand_level(),
               1'($urandom_range(0, 1)));
      run_random(17);
    end

    $display("Checked %0d colours over %0d register settings, with %0d curve writes",
             pixels_checked, settings_run, curve_writes);
    $display("including a full curve load and a long output stall; %0d errors",
             error_count);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* rgb555_color_adjust.f */
sv/rca_pkg.sv
sv/rca_front.sv
sv/rca_fifo.sv
sv/rca_back.sv
sv/rgb555_color_adjust.sv
verif/tb_top.sv
